// ----- design/lpmd_pkg.sv -----
// Shared types and constants for the length-prefixed message deframer.
// Used by the deframer top level, its port checker and the testbench; depends on nothing.
package lpmd_pkg;

	localparam int HEADER_BYTES = 4;
	localparam logic [15:0] MAX_FIELD_RESET = 16'd2048;

	typedef enum logic [2:0] {
		EV_HEADER  = 3'd0,
		EV_PAYLOAD = 3'd1,
		EV_EMPTY   = 3'd2,
		EV_BAD_ID  = 3'd3,
		EV_BAD_LEN = 3'd4,
		EV_LINK    = 3'd5,
		EV_DROP    = 3'd6
	} event_t;

endpackage

// ----- design/length_prefixed_message_deframer.sv -----
// Length-prefixed message deframer: splits a byte stream into tagged messages.
// Depends on lpmd_pkg for event codes and header constants.
//
// One result beat leaves for every input beat, in order, by way of an input
// register and then one pass of header/payload logic into the
// result register. A new byte is taken every cycle while the result side keeps
// up; a stall on the result side holds both stages and reaches the input stall
// in the same cycle. The maximum id/length register may be written at any
// time the block is idle and is always ready.
module length_prefixed_message_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        link_error,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_res,
	output logic [7:0]  payload_byte,
	output logic [15:0] message_id,
	output logic [15:0] message_length,
	output logic        first_of_message,
	output logic        last_of_message,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import lpmd_pkg::*;

	localparam int CntW = $clog2(HEADER_BYTES);
	localparam int ShiftW = 8 * (HEADER_BYTES - 1);
	localparam logic [CntW-1:0] HdrLast = CntW'(HEADER_BYTES - 1);

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_CLOSED  = 2'd2
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [CntW-1:0]   hdr_cnt_q, hdr_cnt_d;
	logic [ShiftW-1:0] hdr_shift_q, hdr_shift_d;
	logic [15:0]       cur_id_q, cur_id_d;
	logic [15:0]       cur_len_q, cur_len_d;
	logic [15:0]       left_q, left_d;
	logic [15:0]       max_q;

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       link_error_s1;

	logic        valid_s2;
	event_t      event_s2, event_d;
	logic [7:0]  byte_s2, byte_d;
	logic [15:0] id_s2, id_d;
	logic [15:0] len_s2, len_d;
	logic        first_s2, first_d;
	logic        last_s2, last_d;

	logic advance;
	logic load;
	logic [15:0] hdr_id;
	logic [15:0] hdr_len;

	assign advance = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign load = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign hdr_id = hdr_shift_q[ShiftW-1 -: 16];
	assign hdr_len = {hdr_shift_q[7:0], rx_byte_s1};

	always_comb begin
		phase_d = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		hdr_shift_d = hdr_shift_q;
		cur_id_d = cur_id_q;
		cur_len_d = cur_len_q;
		left_d = left_q;
		event_d = EV_DROP;
		byte_d = 8'd0;
		id_d = 16'd0;
		len_d = 16'd0;
		first_d = 1'b0;
		last_d = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				if (link_error_s1) begin
					phase_d = PH_CLOSED;
					event_d = EV_LINK;
				end else if (hdr_cnt_q != HdrLast) begin
					hdr_shift_d = {hdr_shift_q[ShiftW-9:0], rx_byte_s1};
					hdr_cnt_d = hdr_cnt_q + 1'b1;
					event_d = EV_HEADER;
				end else begin
					hdr_cnt_d = '0;
					hdr_shift_d = '0;
					cur_id_d = hdr_id;
					cur_len_d = hdr_len;
					id_d = hdr_id;
					len_d = hdr_len;
					if (hdr_id > max_q) begin
						phase_d = PH_CLOSED;
						event_d = EV_BAD_ID;
					end else if (hdr_len > max_q) begin
						phase_d = PH_CLOSED;
						event_d = EV_BAD_LEN;
					end else if (hdr_len == 16'd0) begin
						left_d = 16'd0;
						event_d = EV_EMPTY;
						last_d = 1'b1;
					end else begin
						left_d = hdr_len;
						phase_d = PH_PAYLOAD;
						event_d = EV_HEADER;
					end
				end
			end
			PH_PAYLOAD: begin
				if (link_error_s1) begin
					phase_d = PH_CLOSED;
					event_d = EV_LINK;
				end else begin
					event_d = EV_PAYLOAD;
					byte_d = rx_byte_s1;
					id_d = cur_id_q;
					len_d = cur_len_q;
					first_d = (left_q == cur_len_q);
					last_d = (left_q <= 16'd1);
					if (left_q <= 16'd1) begin
						left_d = 16'd0;
						phase_d = PH_HEADER;
					end else begin
						left_d = left_q - 16'd1;
					end
				end
			end
			default: begin
				event_d = EV_DROP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			phase_q <= PH_HEADER;
			hdr_cnt_q <= '0;
			hdr_shift_q <= '0;
			cur_id_q <= 16'd0;
			cur_len_q <= 16'd0;
			left_q <= 16'd0;
			max_q <= MAX_FIELD_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_q <= cfg_data;
			end
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				phase_q <= phase_d;
				hdr_cnt_q <= hdr_cnt_d;
				hdr_shift_q <= hdr_shift_d;
				cur_id_q <= cur_id_d;
				cur_len_q <= cur_len_d;
				left_q <= left_d;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rx_byte_s1 <= rx_byte;
			link_error_s1 <= link_error;
		end
		if (advance) begin
			event_s2 <= event_d;
			byte_s2 <= byte_d;
			id_s2 <= id_d;
			len_s2 <= len_d;
			first_s2 <= first_d;
			last_s2 <= last_d;
		end
	end

	assign out_valid = valid_s2;
	assign event_res = event_s2;
	assign payload_byte = byte_s2;
	assign message_id = id_s2;
	assign message_length = len_s2;
	assign first_of_message = first_s2;
	assign last_of_message = last_s2;

endmodule

// ----- design/lpmd_checker.sv -----
// Port-level checker for the length-prefixed message deframer, bound to the top level.
// Depends on lpmd_pkg for the event codes.
module lpmd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  event_res,
	input logic [7:0]  payload_byte,
	input logic [15:0] message_id,
	input logic [15:0] message_length,
	input logic        first_of_message,
	input logic        last_of_message
);
	import lpmd_pkg::*;

	// A stalled result beat holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_res)
			&& $stable(payload_byte) && $stable(message_id))
		else $error("stalled result beat changed");

	// Only payload beats carry a byte or a first mark.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_PAYLOAD |-> payload_byte == 8'd0 && !first_of_message)
		else $error("byte or first mark outside a payload beat");

	// The last mark appears only on payload beats and empty messages.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_message |-> event_res == EV_PAYLOAD || event_res == EV_EMPTY)
		else $error("last mark on a wrong event");

	// Once the session closes, any following beat is a drop.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && (event_res == EV_LINK || event_res == EV_BAD_ID
			|| event_res == EV_BAD_LEN || event_res == EV_DROP)
		|=> !out_valid || event_res == EV_DROP)
		else $error("beat other than drop after session closed");

endmodule

bind length_prefixed_message_deframer lpmd_checker u_lpmd_checker (.*);

// ----- sim/length_prefixed_message_deframer_tb.sv -----
// Self-checking testbench for the length-prefixed message deframer.
// It predicts one result beat per input byte and compares every field.
// Depends on lpmd_pkg and the length_prefixed_message_deframer RTL.
module length_prefixed_message_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lpmd_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	typedef enum logic [1:0] {
		ST_HEADER,
		ST_PAYLOAD,
		ST_CLOSED
	} rx_state_t;

	typedef struct {
		logic [7:0] data;
		logic       err;
	} rx_beat_t;

	typedef struct {
		event_t      ev;
		logic [7:0]  data;
		logic [15:0] id;
		logic [15:0] len;
		logic        first;
		logic        last;
	} deframed_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'd0;
	logic        link_error = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  event_res;
	logic [7:0]  payload_byte;
	logic [15:0] message_id;
	logic [15:0] message_length;
	logic        first_of_message;
	logic        last_of_message;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'd0;

	rx_beat_t  queued_bytes[$];
	deframed_t due_records[$];
	int        item_total = 0;
	int        error_count = 0;
	int        results_seen = 0;
	int        cycle_count = 0;

	rx_state_t   rx_state = ST_HEADER;
	logic [1:0]  hdr_count = 2'd0;
	logic [23:0] hdr_shift = 24'd0;
	logic [15:0] cur_id = 16'd0;
	logic [15:0] cur_len = 16'd0;
	logic [15:0] bytes_left = 16'd0;
	logic [15:0] max_field = MAX_FIELD_RESET;

	int   send_gap = 0;
	int   stall_left = 0;
	int   free_left = 0;
	logic long_hold_done = 1'b0;

	length_prefixed_message_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.link_error(link_error),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.payload_byte(payload_byte),
		.message_id(message_id),
		.message_length(message_length),
		.first_of_message(first_of_message),
		.last_of_message(last_of_message),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic deframed_t deframe_byte(input logic [7:0] b, input logic err);
		deframed_t   r;
		logic [15:0] hid;
		logic [15:0] hlen;
		r = '{ev: EV_DROP, data: 8'd0, id: 16'd0, len: 16'd0, first: 1'b0, last: 1'b0};
		hid = hdr_shift[23:8];
		hlen = {hdr_shift[7:0], b};
		if (rx_state != ST_HEADER && rx_state != ST_PAYLOAD)
			return r;
		if (err) begin
			rx_state = ST_CLOSED;
			r.ev = EV_LINK;
			return r;
		end
		if (rx_state == ST_HEADER) begin
			if (hdr_count < HEADER_BYTES - 1) begin
				hdr_shift = {hdr_shift[15:0], b};
				hdr_count = hdr_count + 2'd1;
				r.ev = EV_HEADER;
				return r;
			end
			hdr_count = 2'd0;
			hdr_shift = 24'd0;
			cur_id = hid;
			cur_len = hlen;
			r.id = hid;
			r.len = hlen;
			if (hid > max_field) begin
				rx_state = ST_CLOSED;
				r.ev = EV_BAD_ID;
			end else if (hlen > max_field) begin
				rx_state = ST_CLOSED;
				r.ev = EV_BAD_LEN;
			end else if (hlen == 16'd0) begin
				bytes_left = 16'd0;
				r.ev = EV_EMPTY;
				r.last = 1'b1;
			end else begin
				bytes_left = hlen;
				rx_state = ST_PAYLOAD;
				r.ev = EV_HEADER;
			end
			return r;
		end
		r.ev = EV_PAYLOAD;
		r.data = b;
		r.id = cur_id;
		r.len = cur_len;
		r.first = (bytes_left == cur_len);
		r.last = (bytes_left <= 16'd1);
		if (r.last) begin
			bytes_left = 16'd0;
			rx_state = ST_HEADER;
		end else begin
			bytes_left = bytes_left - 16'd1;
		end
		return r;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 6)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 30);
		return $urandom_range(1, 3);
	endfunction

	// Sender: a beat stays on the bus unchanged until it is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && in_stall) begin
			in_valid <= 1'b1;
		end else begin
			if (in_valid) begin
				due_records.push_back(deframe_byte(rx_byte, link_error));
				void'(queued_bytes.pop_front());
			end
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (queued_bytes.size() > 0) begin
				in_valid <= 1'b1;
				rx_byte <= queued_bytes[0].data;
				link_error <= queued_bytes[0].err;
				send_gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure, with one long hold-off while the sender has plenty queued.
	always @(posedge clk) begin
		if (!long_hold_done && results_seen >= 200 && queued_bytes.size() > 80) begin
			long_hold_done = 1'b1;
			stall_left = 300;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (free_left > 0) begin
			free_left--;
			out_stall <= 1'b0;
		end else if ($urandom_range(0, 1) == 1) begin
			free_left = $urandom_range(0, 40);
			out_stall <= 1'b0;
		end else begin
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
				: $urandom_range(0, 2);
			out_stall <= 1'b1;
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		deframed_t exp_rec;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (due_records.size() == 0) begin
				$error("result beat with no prediction pending, event 0x%0h", event_res);
				error_count++;
			end else begin
				exp_rec = due_records.pop_front();
				check_field("event_res", 16'(exp_rec.ev), 16'(event_res));
				check_field("payload_byte", 16'(exp_rec.data), 16'(payload_byte));
				check_field("message_id", exp_rec.id, message_id);
				check_field("message_length", exp_rec.len, message_length);
				check_field("first_of_message", 16'(exp_rec.first), 16'(first_of_message));
				check_field("last_of_message", 16'(exp_rec.last), 16'(last_of_message));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic queue_byte(input logic [7:0] b, input logic err);
		rx_beat_t beat;
		beat.data = b;
		beat.err = err;
		queued_bytes.push_back(beat);
		item_total++;
	endtask

	task automatic queue_header(input logic [15:0] id, input logic [15:0] len);
		queue_byte(id[15:8], 1'b0);
		queue_byte(id[7:0], 1'b0);
		queue_byte(len[15:8], 1'b0);
		queue_byte(len[7:0], 1'b0);
	endtask

	// Queues a message with random payload, cut short after keep beats.
	task automatic queue_message(input logic [15:0] id, input logic [15:0] len,
		input int keep);
		int n;
		n = 0;
		for (int i = 0; i < 4; i++) begin
			if (n < keep)
				queue_byte(i == 0 ? id[15:8] : i == 1 ? id[7:0] : i == 2 ? len[15:8]
					: len[7:0], 1'b0);
			n++;
		end
		for (int i = 0; i < len; i++) begin
			if (n < keep)
				queue_byte(8'($urandom_range(0, 255)), 1'b0);
			n++;
		end
	endtask

	task automatic wait_drained();
		while (queued_bytes.size() > 0 || due_records.size() > 0 || in_valid)
			@(posedge clk);
	endtask

	task automatic write_max(input logic [15:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		max_field = v;
	endtask

	initial begin
		int mx;
		int id;
		int len;
		int pick;
		int phase_start;
		int close_kind;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Limit at its reset value: empty message, id at the limit, byte extremes.
		queue_header(16'h0000, 16'h0000);
		queue_header(16'h0800, 16'h0002);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_header(16'h00FF, 16'h0001);
		queue_byte(8'hA5, 1'b0);
		wait_drained();

		// Largest limit: nothing is rejected, all-ones id.
		write_max(16'hFFFF);
		queue_header(16'hFFFF, 16'h0000);
		queue_header(16'h1234, 16'h0003);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h5A, 1'b0);
		wait_drained();

		// Zero limit: only empty messages with id zero pass.
		write_max(16'h0000);
		queue_header(16'h0000, 16'h0000);
		queue_header(16'h0000, 16'h0000);
		wait_drained();

		while (item_total < 900) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				mx = $urandom_range(0, 3);
			else if (pick <= 5)
				mx = $urandom_range(4, 300);
			else if (pick <= 8)
				mx = $urandom_range(300, 65534);
			else
				mx = 65535;
			write_max(16'(mx));
			phase_start = item_total;
			while (item_total - phase_start < 130 && item_total < 900) begin
				id = ($urandom_range(0, 4) == 0) ? mx : $urandom_range(0, mx);
				pick = $urandom_range(0, 19);
				if (pick < 12)
					len = $urandom_range(0, 6);
				else if (pick < 19)
					len = $urandom_range(7, 40);
				else
					len = $urandom_range(41, 300);
				if (len > mx || (mx <= 40 && $urandom_range(0, 3) == 0))
					len = mx;
				queue_message(16'(id), 16'(len), 1 << 30);
			end
			wait_drained();
		end

		// The session can close only once per run, so one closing cause is chosen here.
		mx = $urandom_range(0, 4000);
		write_max(16'(mx));
		close_kind = $urandom_range(0, 3);
		len = $urandom_range(0, (mx < 10) ? mx : 10);
		if (close_kind == 0) begin
			queue_message(16'($urandom_range(0, mx)), 16'(len), $urandom_range(0, 4 + len));
			queue_byte(8'($urandom_range(0, 255)), 1'b1);
		end else begin
			queue_message(16'($urandom_range(0, mx)), 16'(len), 1 << 30);
			if (close_kind == 1)
				queue_header(16'($urandom_range(mx + 1, 65535)), 16'($urandom_range(0, mx)));
			else if (close_kind == 2)
				queue_header(16'($urandom_range(0, mx)), 16'($urandom_range(mx + 1, 65535)));
			else
				queue_header(16'($urandom_range(mx + 1, 65535)),
					16'($urandom_range(mx + 1, 65535)));
		end
		repeat (30)
			queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		wait_drained();
		repeat (8) @(posedge clk);

		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
design/lpmd_pkg.sv
design/length_prefixed_message_deframer.sv
design/lpmd_checker.sv
sim/length_prefixed_message_deframer_tb.sv
